/* sv/lhte_pkg.sv */
// Shared constants, codes and handshake payload types of the hash table engine.
`default_nettype none

package lhte_pkg;

    localparam int LHTE_TABLE_DEPTH = 256;
    localparam int LHTE_KEY_BITS    = 32;
    localparam int LHTE_HANDLE_BITS = 32;

    localparam int OPCODE_W = 2;
    localparam int FIELD_W  = 32;
    localparam int HASH_W   = 32;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SEARCH = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [FIELD_W-1:0]  key;
        logic [HASH_W-1:0]   hash_value;
        logic [FIELD_W-1:0]  record_handle;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [FIELD_W-1:0] found_handle;
        logic [INDEX_W-1:0] found_index;
        logic [COUNT_W-1:0] entry_count_now;
    } t_rsp;

    // Sequencer status towards the top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_stat;

endpackage

`default_nettype wire

/* sv/lhte_req_if.sv */
// Request channel interface: valid/ready and one request item.
`default_nettype none

interface lhte_req_if;
    import lhte_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [FIELD_W-1:0]  key;
    logic [HASH_W-1:0]   hash_value;
    logic [FIELD_W-1:0]  record_handle;

    modport source (output valid, output opcode, output key, output hash_value,
                    output record_handle, input ready);
    modport sink (input valid, input opcode, input key, input hash_value,
                  input record_handle, output ready);
endinterface

`default_nettype wire

/* sv/lhte_rsp_if.sv */
// Response channel interface: valid/ready and one result item.
`default_nettype none

interface lhte_rsp_if;
    import lhte_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  found_handle;
    logic [INDEX_W-1:0]  found_index;
    logic [COUNT_W-1:0]  entry_count_now;

    modport source (output valid, output status, output found_handle,
                    output found_index, output entry_count_now, input ready);
    modport sink (input valid, input status, input found_handle,
                  input found_index, input entry_count_now, output ready);
endinterface

`default_nettype wire

/* sv/lhte_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lhte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/lhte_seq.sv */
// Operation sequencer: walks and relinks bucket chains held in the link and entry RAMs.
`default_nettype none

module lhte_seq import lhte_pkg::*; #(
    parameter int TABLE_DEPTH = LHTE_TABLE_DEPTH,
    parameter int KEY_BITS    = LHTE_KEY_BITS,
    parameter int HANDLE_BITS = LHTE_HANDLE_BITS,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int LW = AW + 1,
    localparam int DW = HASH_W + HANDLE_BITS + KEY_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire t_req          i_req,
    input  wire logic          i_uniq,
    input  wire logic          i_take,
    output t_seq_stat          o_stat,
    output t_rsp               o_rsp,
    output logic [AW-1:0]      o_raddr,
    output logic               o_lwe,
    output logic [AW-1:0]      o_lwaddr,
    output logic [LW-1:0]      o_lwdata,
    input  wire logic [LW-1:0] i_lrdata,
    output logic               o_dwe,
    output logic [AW-1:0]      o_dwaddr,
    output logic [DW-1:0]      o_dwdata,
    input  wire logic [DW-1:0] i_drdata
);

    localparam int CW = AW + 1;
    localparam int SW = AW + 2;
    localparam logic [LW-1:0] LINK_NONE = LW'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH,
        S_F_RD, S_F_CHK, S_F_MISS,
        S_I_CHKFULL, S_I_START, S_I_RD, S_I_CHK, S_I_FIX1, S_I_FIX2,
        S_I_TAIL, S_I_MOVE, S_I_LINK, S_I_FIN,
        S_D_RD, S_D_CHK, S_D_UNLINK, S_D_PULL, S_D_CMP, S_D_LAST, S_D_POS,
        S_D_MV, S_D_FIXP,
        S_R_RD, S_R_CHK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic hdn;
        logic hs;
        logic ld;
        logic ls;
    } t_flags;

    function automatic logic [AW-1:0] slot(input logic [SW-1:0] i);
        slot = (i < SW'(TABLE_DEPTH)) ? i[AW-1:0] : '0;
    endfunction

    function automatic logic [SW-1:0] bkt(input logic [HASH_W-1:0] h,
                                          input logic [SW-1:0] span,
                                          input logic [CW-1:0] len);
        logic [SW-1:0] hs;
        logic [SW-1:0] a;
        hs = h[SW-1:0];
        a  = hs & (span - 1'b1);
        if (a < SW'(len)) begin
            bkt = a;
        end else begin
            bkt = hs & ((span >> 1) - 1'b1);
        end
    endfunction

    t_state r_state, n_state, r_ret, n_ret;
    logic [OPCODE_W-1:0] r_op, n_op;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [HASH_W-1:0] r_hash, n_hash;
    logic [HANDLE_BITS-1:0] r_hd, n_hd;
    logic [CW-1:0] r_cnt, n_cnt, r_n, n_n, r_fst, n_fst;
    logic [SW-1:0] r_span, n_span, r_ospan, n_ospan, r_g, n_g;
    logic [AW-1:0] r_pos, n_pos, r_gp, n_gp, r_gp2, n_gp2, r_empty, n_empty;
    logic [AW-1:0] r_cur, n_cur;
    logic [LW-1:0] r_prev, n_prev, r_lnk, n_lnk, r_llink, n_llink;
    logic [LW-1:0] r_target, n_target, r_dest, n_dest;
    logic r_first, n_first;
    t_flags r_flags, n_flags;
    logic [DW-1:0] r_d1, n_d1, r_d2, n_d2, r_ldat, n_ldat;
    t_status r_status, n_status;
    logic [FIELD_W-1:0] r_fh, n_fh;
    logic [INDEX_W-1:0] r_fi, n_fi;

    logic [HASH_W-1:0] rd_hash, ld_hash;
    logic [HANDLE_BITS-1:0] rd_handle;
    logic [KEY_BITS-1:0] rd_key;
    logic [DW-1:0] new_data;

    assign rd_hash   = i_drdata[DW-1 -: HASH_W];
    assign rd_handle = i_drdata[KEY_BITS +: HANDLE_BITS];
    assign rd_key    = i_drdata[KEY_BITS-1:0];
    assign ld_hash   = r_ldat[DW-1 -: HASH_W];
    assign new_data  = {r_hash, r_hd, r_key};

    always_comb begin
        logic [SW-1:0] half_v;
        logic [AW-1:0] p_v;
        logic [AW-1:0] p3_v;
        logic [SW-1:0] p2_v;
        logic [SW-1:0] q_v;
        logic [CW-1:0] dec_v;

        n_state = r_state; n_ret = r_ret; n_op = r_op; n_key = r_key;
        n_hash = r_hash; n_hd = r_hd; n_cnt = r_cnt; n_n = r_n; n_fst = r_fst;
        n_span = r_span; n_ospan = r_ospan; n_g = r_g; n_pos = r_pos;
        n_gp = r_gp; n_gp2 = r_gp2; n_empty = r_empty; n_cur = r_cur;
        n_prev = r_prev; n_lnk = r_lnk; n_llink = r_llink;
        n_target = r_target; n_dest = r_dest; n_first = r_first;
        n_flags = r_flags; n_d1 = r_d1; n_d2 = r_d2; n_ldat = r_ldat;
        n_status = r_status; n_fh = r_fh; n_fi = r_fi;

        o_raddr  = r_pos;
        o_lwe    = 1'b0;
        o_lwaddr = r_pos;
        o_lwdata = LINK_NONE;
        o_dwe    = 1'b0;
        o_dwaddr = r_pos;
        o_dwdata = new_data;

        half_v = r_span >> 1;
        p_v    = slot(bkt(rd_hash, r_span, r_cnt));
        p3_v   = p_v;
        p2_v   = bkt(ld_hash, r_ospan, r_cnt + 1'b1);
        q_v    = bkt(rd_hash, r_ospan, r_cnt + 1'b1);
        dec_v  = r_cnt - 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_req.opcode;
                    n_key   = KEY_BITS'(i_req.key);
                    n_hash  = i_req.hash_value;
                    n_hd    = HANDLE_BITS'(i_req.record_handle);
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_status = ST_MISS;
                n_fh     = '0;
                n_fi     = '0;
                n_pos    = slot(bkt(r_hash, r_span, r_cnt));
                n_n      = '0;
                n_first  = 1'b1;
                n_prev   = LINK_NONE;
                if (r_op == OP_SEARCH || (r_op == OP_INSERT && i_uniq)) begin
                    n_state = (r_cnt == '0) ? S_F_MISS : S_F_RD;
                end else if (r_op == OP_INSERT) begin
                    n_state = S_I_CHKFULL;
                end else if (r_op == OP_DELETE) begin
                    n_state = (r_cnt == '0) ? S_DONE : S_D_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            // key lookup along one chain
            S_F_RD: begin
                n_state = S_F_CHK;
            end
            S_F_CHK: begin
                if (rd_key == r_key) begin
                    if (r_op == OP_SEARCH) begin
                        n_status = ST_OK;
                        n_fh     = FIELD_W'(rd_handle);
                        n_fi     = INDEX_W'(r_pos);
                    end else begin
                        n_status = ST_DUP;
                    end
                    n_state = S_DONE;
                end else if (r_first && bkt(rd_hash, r_span, r_cnt) != SW'(r_pos)) begin
                    n_state = S_F_MISS;
                end else if (i_lrdata == LINK_NONE || r_n >= CW'(TABLE_DEPTH)) begin
                    n_state = S_F_MISS;
                end else begin
                    n_n     = r_n + 1'b1;
                    n_pos   = slot(SW'(i_lrdata));
                    n_first = 1'b0;
                    n_state = S_F_RD;
                end
            end
            S_F_MISS: begin
                n_state = (r_op == OP_SEARCH) ? S_DONE : S_I_CHKFULL;
            end
            // insert: split the chain of the bucket that is being divided
            S_I_CHKFULL: begin
                if (r_cnt >= CW'(TABLE_DEPTH)) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_I_START;
                end
            end
            S_I_START: begin
                n_flags = '0;
                n_empty = r_cnt[AW-1:0];
                n_gp    = '0;
                n_gp2   = '0;
                n_n     = '0;
                n_fst   = r_cnt - CW'(half_v);
                n_pos   = slot(SW'(r_cnt - CW'(half_v)));
                n_state = (half_v == '0) ? S_I_TAIL : S_I_RD;
            end
            S_I_RD: begin
                n_state = S_I_CHK;
            end
            S_I_CHK: begin
                if (r_flags == '0 && bkt(rd_hash, r_span, r_cnt) != SW'(r_fst)) begin
                    n_state = S_I_FIX1;
                end else begin
                    if ((rd_hash[SW-1:0] & half_v) == '0) begin
                        if (!r_flags.ls) begin
                            if (r_flags.hs) begin
                                n_flags = '{hdn: 1'b0, hs: 1'b1, ld: 1'b0, ls: 1'b1};
                                n_gp    = r_empty;
                                n_empty = r_pos;
                            end else begin
                                n_flags = '{hdn: 1'b0, hs: 1'b0, ld: 1'b1, ls: 1'b1};
                                n_gp    = r_pos;
                            end
                        end else begin
                            if (!r_flags.ld) begin
                                o_dwe    = 1'b1;
                                o_dwaddr = r_gp;
                                o_dwdata = r_d1;
                                o_lwe    = 1'b1;
                                o_lwaddr = r_gp;
                                o_lwdata = LW'(r_pos);
                                n_flags  = '{hdn: 1'b0, hs: r_flags.hs, ld: 1'b1, ls: 1'b1};
                            end
                            n_gp = r_pos;
                        end
                        n_d1 = i_drdata;
                    end else begin
                        if (!r_flags.hs) begin
                            n_flags = '{hdn: 1'b0, hs: 1'b1, ld: 1'b0, ls: r_flags.ls};
                            n_gp2   = r_empty;
                            n_empty = r_pos;
                        end else begin
                            if (!r_flags.hdn) begin
                                o_dwe    = 1'b1;
                                o_dwaddr = r_gp2;
                                o_dwdata = r_d2;
                                o_lwe    = 1'b1;
                                o_lwaddr = r_gp2;
                                o_lwdata = LW'(r_pos);
                                n_flags  = '{hdn: 1'b1, hs: 1'b1, ld: 1'b0, ls: r_flags.ls};
                            end
                            n_gp2 = r_pos;
                        end
                        n_d2 = i_drdata;
                    end
                    if (i_lrdata == LINK_NONE || r_n >= CW'(TABLE_DEPTH)) begin
                        n_state = S_I_FIX1;
                    end else begin
                        n_n     = r_n + 1'b1;
                        n_pos   = slot(SW'(i_lrdata));
                        n_state = S_I_RD;
                    end
                end
            end
            S_I_FIX1: begin
                // close the low chain if its last entry is still pending
                if (r_flags.ls && !r_flags.ld) begin
                    o_dwe    = 1'b1;
                    o_dwaddr = r_gp;
                    o_dwdata = r_d1;
                    o_lwe    = 1'b1;
                    o_lwaddr = r_gp;
                end
                n_state = S_I_FIX2;
            end
            S_I_FIX2: begin
                if (r_flags.hs && !r_flags.hdn) begin
                    o_dwe    = 1'b1;
                    o_dwaddr = r_gp2;
                    o_dwdata = r_d2;
                    o_lwe    = 1'b1;
                    o_lwaddr = r_gp2;
                end
                n_state = S_I_TAIL;
            end
            S_I_TAIL: begin
                n_pos = slot(bkt(r_hash, r_span, r_cnt + 1'b1));
                if (slot(bkt(r_hash, r_span, r_cnt + 1'b1)) == r_empty) begin
                    o_lwe    = 1'b1;
                    o_lwaddr = r_empty;
                    o_dwe    = 1'b1;
                    o_dwaddr = r_empty;
                    n_state  = S_I_FIN;
                end else begin
                    o_raddr = slot(bkt(r_hash, r_span, r_cnt + 1'b1));
                    n_state = S_I_MOVE;
                end
            end
            S_I_MOVE: begin
                // move the entry in the way to the free position
                o_lwe    = 1'b1;
                o_lwaddr = r_empty;
                o_lwdata = i_lrdata;
                o_dwe    = 1'b1;
                o_dwaddr = r_empty;
                o_dwdata = i_drdata;
                n_g      = bkt(rd_hash, r_span, r_cnt + 1'b1);
                n_state  = S_I_LINK;
            end
            S_I_LINK: begin
                o_lwe = 1'b1;
                o_dwe = 1'b1;
                if (r_g == SW'(r_pos)) begin
                    o_lwdata = LW'(r_empty);
                    n_state  = S_I_FIN;
                end else begin
                    n_cur    = slot(r_g);
                    n_target = LW'(r_pos);
                    n_dest   = LW'(r_empty);
                    n_ret    = S_I_FIN;
                    n_n      = '0;
                    n_state  = S_R_RD;
                end
            end
            S_I_FIN: begin
                n_cnt    = r_cnt + 1'b1;
                n_status = ST_OK;
                if (SW'(r_cnt + 1'b1) == r_span) begin
                    n_span = r_span << 1;
                end
                n_state = S_DONE;
            end
            // delete: find the entry by handle
            S_D_RD: begin
                n_state = S_D_CHK;
            end
            S_D_CHK: begin
                if (rd_handle == r_hd) begin
                    n_lnk    = i_lrdata;
                    n_cnt    = dec_v;
                    n_ospan  = r_span;
                    n_status = ST_OK;
                    if (SW'(dec_v) < half_v) begin
                        n_span = half_v;
                    end
                    n_state = S_D_UNLINK;
                end else begin
                    n_prev = LW'(r_pos);
                    if (i_lrdata == LINK_NONE || r_n >= CW'(TABLE_DEPTH)) begin
                        n_state = S_DONE;
                    end else begin
                        n_n     = r_n + 1'b1;
                        n_pos   = slot(SW'(i_lrdata));
                        n_state = S_D_RD;
                    end
                end
            end
            S_D_UNLINK: begin
                n_empty = r_pos;
                if (r_prev != LINK_NONE) begin
                    o_lwe    = 1'b1;
                    o_lwaddr = slot(SW'(r_prev));
                    o_lwdata = r_lnk;
                    n_state  = S_D_CMP;
                end else if (r_lnk != LINK_NONE) begin
                    n_empty = slot(SW'(r_lnk));
                    o_raddr = slot(SW'(r_lnk));
                    n_state = S_D_PULL;
                end else begin
                    n_state = S_D_CMP;
                end
            end
            S_D_PULL: begin
                o_lwe    = 1'b1;
                o_lwdata = i_lrdata;
                o_dwe    = 1'b1;
                o_dwdata = i_drdata;
                n_state  = S_D_CMP;
            end
            S_D_CMP: begin
                if (SW'(r_empty) == SW'(r_cnt)) begin
                    n_state = S_DONE;
                end else begin
                    o_raddr = slot(SW'(r_cnt));
                    n_state = S_D_LAST;
                end
            end
            S_D_LAST: begin
                n_ldat  = i_drdata;
                n_llink = i_lrdata;
                n_pos   = p_v;
                if (p_v == r_empty) begin
                    o_lwe    = 1'b1;
                    o_lwaddr = r_empty;
                    o_lwdata = i_lrdata;
                    o_dwe    = 1'b1;
                    o_dwaddr = r_empty;
                    o_dwdata = i_drdata;
                    n_state  = S_DONE;
                end else begin
                    o_raddr = p_v;
                    n_state = S_D_POS;
                end
            end
            S_D_POS: begin
                o_lwe    = 1'b1;
                o_lwaddr = r_empty;
                o_dwe    = 1'b1;
                o_dwaddr = r_empty;
                n_n      = '0;
                n_dest   = LW'(r_empty);
                n_ret    = S_DONE;
                if (r_pos != p3_v) begin
                    // entry at the home position belongs elsewhere: evict it
                    o_lwdata = i_lrdata;
                    o_dwdata = i_drdata;
                    n_cur    = p3_v;
                    n_target = LW'(r_pos);
                    n_state  = S_D_MV;
                end else begin
                    o_lwdata = r_llink;
                    o_dwdata = r_ldat;
                    n_state  = S_R_RD;
                    if (p2_v == q_v && p2_v != SW'(r_cnt)) begin
                        n_target = LW'(r_cnt);
                        n_cur    = r_pos;
                    end else begin
                        n_target = (p2_v == q_v) ? LW'(r_pos) : LINK_NONE;
                        n_cur    = r_empty;
                        n_dest   = i_lrdata;
                        n_ret    = S_D_FIXP;
                    end
                end
            end
            S_D_MV: begin
                o_lwe    = 1'b1;
                o_lwdata = r_llink;
                o_dwe    = 1'b1;
                o_dwdata = r_ldat;
                n_state  = S_R_RD;
            end
            S_D_FIXP: begin
                o_lwe    = 1'b1;
                o_lwdata = LW'(r_empty);
                n_state  = S_DONE;
            end
            // relink: walk until an entry points at the target, repoint it
            S_R_RD: begin
                o_raddr = r_cur;
                n_state = S_R_CHK;
            end
            S_R_CHK: begin
                if (r_n >= CW'(TABLE_DEPTH + 1)) begin
                    n_state = r_ret;
                end else if (i_lrdata == r_target) begin
                    o_lwe    = 1'b1;
                    o_lwaddr = r_cur;
                    o_lwdata = r_dest;
                    n_state  = r_ret;
                end else begin
                    n_n     = r_n + 1'b1;
                    n_cur   = slot(SW'(i_lrdata));
                    n_state = S_R_RD;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_span  <= SW'(1);
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_span  <= n_span;
        end
        r_ret <= n_ret; r_op <= n_op; r_key <= n_key; r_hash <= n_hash; r_hd <= n_hd;
        r_n <= n_n; r_fst <= n_fst; r_ospan <= n_ospan; r_g <= n_g; r_pos <= n_pos;
        r_gp <= n_gp; r_gp2 <= n_gp2; r_empty <= n_empty; r_cur <= n_cur;
        r_prev <= n_prev; r_lnk <= n_lnk; r_llink <= n_llink;
        r_target <= n_target; r_dest <= n_dest; r_first <= n_first;
        r_flags <= n_flags; r_d1 <= n_d1; r_d2 <= n_d2; r_ldat <= n_ldat;
        r_status <= n_status; r_fh <= n_fh; r_fi <= n_fi;
    end

    assign o_stat.idle           = (r_state == S_IDLE);
    assign o_stat.done           = (r_state == S_DONE);
    assign o_rsp.status          = r_status;
    assign o_rsp.found_handle    = r_fh;
    assign o_rsp.found_index     = r_fi;
    assign o_rsp.entry_count_now = COUNT_W'(r_cnt);

`ifndef SYNTHESIS
    a_span_pow2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_span))
        else $error("bucket span not a power of two");

    a_cnt_below_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SW'(r_cnt) < r_span)
        else $error("entry count reached bucket span");

    a_cnt_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !i_start) |=> $stable(r_cnt))
        else $error("entry count changed while idle");
`endif

endmodule

`default_nettype wire

/* sv/linear_hash_table_engine.sv */
// Top level of the linear-hashing table engine: channels, configuration and RAMs.
`default_nettype none

// Linear-hashing table engine. Entries are packed at positions 0 to count-1 of a link
// RAM and an entry RAM (hash, handle, key); colliding entries chain through the links.
// One item is handled at a time. Each memory step is a registered read followed by a
// check, so a chain walk visits one entry per step: a search walks one bucket chain,
// an insert adds the walk of the bucket chain being split and a possible relink walk,
// a delete the handle walk and a relink walk. The result waits in an output register,
// so the next item is taken once the engine has handed its result on. No clearing
// pass after reset is needed. Write unique_keys only while the engine is idle.
module linear_hash_table_engine import lhte_pkg::*; #(
    parameter int TABLE_DEPTH = LHTE_TABLE_DEPTH,
    parameter int KEY_BITS    = LHTE_KEY_BITS,
    parameter int HANDLE_BITS = LHTE_HANDLE_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    lhte_req_if.sink   i_req,
    lhte_rsp_if.source o_rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = AW + 1;
    localparam int DW = HASH_W + HANDLE_BITS + KEY_BITS;

    logic      r_uniq;
    logic      r_ov;
    t_rsp      r_rsp;
    t_req      req;
    t_rsp      seq_rsp;
    t_seq_stat seq_stat;
    logic      start;
    logic      take;

    logic [AW-1:0] raddr, lwaddr, dwaddr;
    logic          lwe, dwe;
    logic [LW-1:0] lwdata, lrdata;
    logic [DW-1:0] dwdata, drdata;

    assign req.opcode        = i_req.opcode;
    assign req.key           = i_req.key;
    assign req.hash_value    = i_req.hash_value;
    assign req.record_handle = i_req.record_handle;

    assign i_req.ready = seq_stat.idle;
    assign start       = i_req.valid && seq_stat.idle;
    assign take        = !r_ov || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uniq <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_uniq <= i_cfg_wdata;
            end
            if (seq_stat.done && take) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
        if (seq_stat.done && take) begin
            r_rsp <= seq_rsp;
        end
    end

    assign o_rsp.valid           = r_ov;
    assign o_rsp.status          = r_rsp.status;
    assign o_rsp.found_handle    = r_rsp.found_handle;
    assign o_rsp.found_index     = r_rsp.found_index;
    assign o_rsp.entry_count_now = r_rsp.entry_count_now;

    lhte_ram #(.WIDTH(LW), .DEPTH(TABLE_DEPTH)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (lwe),
        .i_waddr (lwaddr),
        .i_wdata (lwdata),
        .i_raddr (raddr),
        .o_rdata (lrdata)
    );

    lhte_ram #(.WIDTH(DW), .DEPTH(TABLE_DEPTH)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (dwe),
        .i_waddr (dwaddr),
        .i_wdata (dwdata),
        .i_raddr (raddr),
        .o_rdata (drdata)
    );

    lhte_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (req),
        .i_uniq   (r_uniq),
        .i_take   (take),
        .o_stat   (seq_stat),
        .o_rsp    (seq_rsp),
        .o_raddr  (raddr),
        .o_lwe    (lwe),
        .o_lwaddr (lwaddr),
        .o_lwdata (lwdata),
        .i_lrdata (lrdata),
        .o_dwe    (dwe),
        .o_dwaddr (dwaddr),
        .o_dwdata (dwdata),
        .i_drdata (drdata)
    );

endmodule

`default_nettype wire

/* bench/tb_linear_hash_table_engine.sv */
// Self-checking bench for the linear-hashing table engine, with its own table predictor.
`timescale 1ns / 100ps

module tb_linear_hash_table_engine;
    import lhte_pkg::*;

    localparam int unsigned DEPTH     = LHTE_TABLE_DEPTH;
    localparam int unsigned LINK_NONE = DEPTH;
    localparam int unsigned LOW_SEEN  = 1;
    localparam int unsigned LOW_DONE  = 2;
    localparam int unsigned HIGH_SEEN = 4;
    localparam int unsigned HIGH_DONE = 8;
    localparam logic [1:0]  OP_SPARE  = 2'd3;
    localparam int          RUN_ITEMS = 1800;

    typedef struct {
        logic [31:0] key;
        logic [31:0] hash;
        logic [31:0] handle;
    } t_entry_ref;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_wdata = 1'b0;

    lhte_req_if req_ch ();
    lhte_rsp_if rsp_ch ();

    linear_hash_table_engine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state
    int unsigned link_t [DEPTH];
    logic [31:0] hash_t [DEPTH];
    logic [31:0] hdl_t  [DEPTH];
    logic [31:0] key_t  [DEPTH];
    int unsigned cnt = 0;
    int unsigned span = 1;
    bit          uniq = 1'b0;

    t_rsp        pending_rsp [$];
    t_entry_ref  live [$];
    int          err_count = 0;
    bit          quiet = 1'b0;
    int          hold_req = 0;

    function automatic int unsigned slot_of(int unsigned i);
        return (i < DEPTH) ? i : 0;
    endfunction

    function automatic int unsigned bucket_of(int unsigned h, int unsigned sp,
                                              int unsigned len);
        int unsigned a;
        a = h & (sp - 1);
        if (a < len) return a;
        return h & ((sp >> 1) - 1);
    endfunction

    function automatic void copy_ent(int unsigned dst, int unsigned src);
        dst = slot_of(dst);
        src = slot_of(src);
        link_t[dst] = link_t[src];
        hash_t[dst] = hash_t[src];
        hdl_t[dst]  = hdl_t[src];
        key_t[dst]  = key_t[src];
    endfunction

    function automatic void put_ent(int unsigned p, logic [31:0] h, logic [31:0] hd,
                                    logic [31:0] k);
        p = slot_of(p);
        hash_t[p] = h;
        hdl_t[p]  = hd;
        key_t[p]  = k;
    endfunction

    // Walk from 'from' to the entry that links to 'target'; point it at 'dest'
    function automatic void relink_chain(int unsigned target, int unsigned from,
                                         int unsigned dest);
        int unsigned cur, n;
        n = 0;
        do begin
            cur = slot_of(from);
            from = link_t[cur];
            n++;
            if (n > DEPTH + 1) return;
        end while (from != target);
        link_t[cur] = dest;
    endfunction

    function automatic int unsigned find_key(logic [31:0] h, logic [31:0] k);
        int unsigned idx, pos, n;
        bit first;
        if (cnt == 0) return LINK_NONE;
        first = 1'b1;
        n = 0;
        idx = bucket_of(h, span, cnt);
        do begin
            pos = slot_of(idx);
            if (key_t[pos] == k) return pos;
            if (first) begin
                first = 1'b0;
                if (bucket_of(hash_t[pos], span, cnt) != pos) break;
            end
            idx = link_t[pos];
            n++;
        end while (idx != LINK_NONE && n <= DEPTH);
        return LINK_NONE;
    endfunction

    function automatic void insert_entry(logic [31:0] h, logic [31:0] k, logic [31:0] hd);
        int unsigned flag, gp, gp2, empty, half, first, idx, pos, g, n;
        logic [31:0] h1, h2, d1, k1, d2, k2, eh;
        flag = 0; gp = 0; gp2 = 0; empty = cnt; n = 0;
        h1 = 0; h2 = 0; d1 = 0; k1 = 0; d2 = 0; k2 = 0;
        half = span >> 1;
        first = cnt - half;
        if (half != 0) begin
            idx = first;
            do begin
                pos = slot_of(idx);
                eh = hash_t[pos];
                if (flag == 0 && bucket_of(eh, span, cnt) != first) break;
                if ((eh & half) == 0) begin
                    if ((flag & LOW_SEEN) == 0) begin
                        if ((flag & HIGH_SEEN) != 0) begin
                            flag = LOW_SEEN | HIGH_SEEN;
                            gp = empty;
                            empty = pos;
                        end else begin
                            flag = LOW_SEEN | LOW_DONE;
                            gp = pos;
                        end
                    end else begin
                        if ((flag & LOW_DONE) == 0) begin
                            put_ent(gp, h1, d1, k1);
                            link_t[slot_of(gp)] = pos;
                            flag = (flag & HIGH_SEEN) | LOW_SEEN | LOW_DONE;
                        end
                        gp = pos;
                    end
                    h1 = eh; d1 = hdl_t[pos]; k1 = key_t[pos];
                end else begin
                    if ((flag & HIGH_SEEN) == 0) begin
                        flag = (flag & LOW_SEEN) | HIGH_SEEN;
                        gp2 = empty;
                        empty = pos;
                    end else begin
                        if ((flag & HIGH_DONE) == 0) begin
                            put_ent(gp2, h2, d2, k2);
                            link_t[slot_of(gp2)] = pos;
                            flag = (flag & LOW_SEEN) | HIGH_SEEN | HIGH_DONE;
                        end
                        gp2 = pos;
                    end
                    h2 = eh; d2 = hdl_t[pos]; k2 = key_t[pos];
                end
                idx = link_t[pos];
                n++;
            end while (idx != LINK_NONE && n <= DEPTH);

            if ((flag & (LOW_SEEN | LOW_DONE)) == LOW_SEEN) begin
                put_ent(gp, h1, d1, k1);
                link_t[slot_of(gp)] = LINK_NONE;
            end
            if ((flag & (HIGH_SEEN | HIGH_DONE)) == HIGH_SEEN) begin
                put_ent(gp2, h2, d2, k2);
                link_t[slot_of(gp2)] = LINK_NONE;
            end
        end

        pos = slot_of(bucket_of(h, span, cnt + 1));
        if (pos == empty) begin
            link_t[pos] = LINK_NONE;
        end else begin
            copy_ent(empty, pos);
            g = bucket_of(hash_t[pos], span, cnt + 1);
            if (g == pos) begin
                link_t[pos] = empty;
            end else begin
                link_t[pos] = LINK_NONE;
                relink_chain(pos, g, empty);
            end
        end
        put_ent(pos, h, hd, k);
        cnt++;
        if (cnt == span) span = span + span;
    endfunction

    // Returns 1 on a miss
    function automatic bit delete_entry(logic [31:0] h, logic [31:0] hd);
        int unsigned old_span, pos, prev, n, last, empty, p3, p2, idx;
        logic [31:0] lh, ph;
        old_span = span; prev = LINK_NONE; n = 0;
        if (cnt == 0) return 1'b1;
        pos = slot_of(bucket_of(h, old_span, cnt));
        while (hdl_t[pos] != hd) begin
            prev = pos;
            if (link_t[pos] == LINK_NONE) return 1'b1;
            n++;
            if (n > DEPTH) return 1'b1;
            pos = slot_of(link_t[pos]);
        end

        cnt--;
        if (cnt < (span >> 1)) span = span >> 1;
        last = cnt;

        empty = pos;
        if (prev != LINK_NONE) begin
            link_t[slot_of(prev)] = link_t[pos];
        end else if (link_t[pos] != LINK_NONE) begin
            empty = slot_of(link_t[pos]);
            copy_ent(pos, empty);
        end
        if (empty == last) return 1'b0;

        lh = hash_t[slot_of(last)];
        pos = slot_of(bucket_of(lh, span, cnt));
        if (pos == empty) begin
            copy_ent(empty, last);
            return 1'b0;
        end
        ph = hash_t[pos];
        p3 = slot_of(bucket_of(ph, span, cnt));
        if (pos != p3) begin
            copy_ent(empty, pos);
            copy_ent(pos, last);
            relink_chain(pos, p3, empty);
            return 1'b0;
        end
        p2 = bucket_of(lh, old_span, cnt + 1);
        if (p2 == bucket_of(ph, old_span, cnt + 1)) begin
            if (p2 != cnt) begin
                copy_ent(empty, last);
                relink_chain(last, pos, empty);
                return 1'b0;
            end
            idx = pos;
        end else begin
            idx = LINK_NONE;
        end
        copy_ent(empty, last);
        relink_chain(idx, empty, link_t[pos]);
        link_t[pos] = empty;
        return 1'b0;
    endfunction

    function automatic t_rsp predict_table_op(t_req r);
        t_rsp        rs;
        int unsigned p;
        rs.status = ST_MISS;
        rs.found_handle = '0;
        rs.found_index = '0;
        case (r.opcode)
            OP_SEARCH: begin
                p = find_key(r.hash_value, r.key);
                if (p != LINK_NONE) begin
                    rs.status = ST_OK;
                    rs.found_handle = hdl_t[p];
                    rs.found_index = p[7:0];
                end
            end
            OP_INSERT: begin
                if (uniq && find_key(r.hash_value, r.key) != LINK_NONE) begin
                    rs.status = ST_DUP;
                end else if (cnt >= DEPTH) begin
                    rs.status = ST_FULL;
                end else begin
                    insert_entry(r.hash_value, r.key, r.record_handle);
                    rs.status = ST_OK;
                end
            end
            OP_DELETE: rs.status = delete_entry(r.hash_value, r.record_handle) ? ST_MISS : ST_OK;
            default: rs.status = ST_MISS;
        endcase
        rs.entry_count_now = cnt[8:0];
        return rs;
    endfunction

    // Keep the list of live entries in step for stimulus choices
    function automatic void track_live(t_req r, t_rsp rs);
        if (rs.status != ST_OK) return;
        if (r.opcode == OP_INSERT) begin
            live.push_back('{key: r.key, hash: r.hash_value, handle: r.record_handle});
        end else if (r.opcode == OP_DELETE) begin
            foreach (live[i]) begin
                if (live[i].handle == r.record_handle) begin
                    live.delete(i);
                    break;
                end
            end
        end
    endfunction

    // Called just after a rising edge; leaves valid high after acceptance
    task automatic send_item(t_req r);
        t_rsp rs;
        if (!quiet && $urandom_range(99) < 7) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= r.opcode;
        req_ch.key <= r.key;
        req_ch.hash_value <= r.hash_value;
        req_ch.record_handle <= r.record_handle;
        do @(posedge i_clk); while (!req_ch.ready);
        rs = predict_table_op(r);
        pending_rsp.push_back(rs);
        track_live(r, rs);
    endtask

    task automatic send_op(logic [1:0] op, logic [31:0] k, logic [31:0] h, logic [31:0] hd);
        t_req r;
        r.opcode = op;
        r.key = k;
        r.hash_value = h;
        r.record_handle = hd;
        send_item(r);
    endtask

    // Hold the sender until every result has been returned
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_unique_keys(bit v);
        drain_results();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        uniq = v;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] fresh_handle();
        logic [31:0] hd;
        bit clash;
        do begin
            hd = $urandom;
            clash = 1'b0;
            foreach (live[i]) if (live[i].handle == hd) clash = 1'b1;
        end while (clash);
        return hd;
    endfunction

    task automatic test_directed();
        logic [31:0] hd;
        write_unique_keys(1'b0);
        send_op(OP_SEARCH, 32'h0, 32'h0, 32'h0);               // empty search
        send_op(OP_DELETE, 32'h1, 32'h1, 32'h1);               // empty delete
        send_op(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 32'h0, 32'h0, 32'h0);
        send_op(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_INSERT, 32'h0, 32'h0, 32'h1234_5678);       // duplicate allowed
        send_op(OP_SEARCH, 32'h0, 32'h0, 32'h0);
        send_op(OP_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        send_op(OP_SEARCH, 32'h5555_AAAA, 32'h2, 32'h0);
        send_op(OP_SPARE, 32'h0, 32'h0, 32'h0);
        write_unique_keys(1'b1);
        send_op(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_5555);   // rejected
        send_op(OP_INSERT, 32'hAAAA_5555, 32'h5555_AAAA, 32'h5555_AAAA);
        send_op(OP_DELETE, 32'h0, 32'h0, 32'hDEAD_0001);       // handle not on chain
        send_op(OP_DELETE, 32'h0, 32'h0, 32'h1234_5678);
        send_op(OP_DELETE, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(OP_SEARCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
        while (live.size() != 0) begin
            hd = live[0].handle;
            send_op(OP_DELETE, 32'h0, live[0].hash, hd);
        end
        send_op(OP_DELETE, 32'h0, 32'h0, 32'h0);
        drain_results();
    endtask

    // Fill to the brim, probe full and duplicate, then empty again
    task automatic test_full_table(bit u);
        t_entry_ref e;
        write_unique_keys(u);
        while (cnt < DEPTH) send_op(OP_INSERT, $urandom, $urandom, fresh_handle());
        send_op(OP_INSERT, $urandom, $urandom, fresh_handle());
        e = live[$urandom_range(live.size() - 1)];
        send_op(OP_INSERT, e.key, e.hash, fresh_handle());
        send_op(OP_SEARCH, e.key, e.hash, 32'h0);
        while (live.size() != 0) begin
            e = live[$urandom_range(live.size() - 1)];
            send_op(OP_DELETE, $urandom, e.hash, e.handle);
        end
        drain_results();
    endtask

    task automatic random_item(int ins_weight);
        t_entry_ref e;
        int pick;
        pick = $urandom_range(99);
        if (live.size() != 0) e = live[$urandom_range(live.size() - 1)];
        if (pick < 3) begin
            send_op($urandom, $urandom, $urandom, $urandom);
        end else if (pick < 3 + ins_weight) begin
            if (live.size() != 0 && $urandom_range(9) == 0)
                send_op(OP_INSERT, e.key, $urandom_range(1) ? e.hash : $urandom,
                        fresh_handle());
            else
                send_op(OP_INSERT, $urandom, $urandom, fresh_handle());
        end else if (pick < 3 + ins_weight + (97 - ins_weight) / 2) begin
            if (live.size() != 0 && $urandom_range(4) != 0)
                send_op(OP_SEARCH, e.key, e.hash, $urandom);
            else
                send_op(OP_SEARCH, $urandom, $urandom, $urandom);
        end else begin
            if (live.size() != 0 && $urandom_range(7) != 0)
                send_op(OP_DELETE, $urandom, e.hash, e.handle);
            else
                send_op(OP_DELETE, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic test_random(bit u);
        write_unique_keys(u);
        for (int i = 0; i < RUN_ITEMS / 2; i++) begin
            quiet = (i >= 200 && i < 320);
            if (i == 400) hold_req = 500;     // receiver holds off, sender keeps going
            if (i == 600) drain_results();
            // alternate insert-heavy and delete-heavy phases to swing the entry count up and down
            random_item(((i / 150) % 2 == 0) ? 70 : 25);
        end
        quiet = 1'b0;
        drain_results();
    endtask

    // Result receiver
    int hold_left = 0;
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= quiet || ($urandom_range(99) >= 7);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result, actual status %0d count %0d", $time,
                         rsp_ch.status, rsp_ch.entry_count_now);
                err_count++;
            end else begin
                want = pending_rsp.pop_front();
                if (rsp_ch.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             rsp_ch.status);
                    err_count++;
                end
                if (rsp_ch.found_handle !== want.found_handle) begin
                    $display("%0t: found_handle expected %h actual %h", $time,
                             want.found_handle, rsp_ch.found_handle);
                    err_count++;
                end
                if (rsp_ch.found_index !== want.found_index) begin
                    $display("%0t: found_index expected %0d actual %0d", $time,
                             want.found_index, rsp_ch.found_index);
                    err_count++;
                end
                if (rsp_ch.entry_count_now !== want.entry_count_now) begin
                    $display("%0t: entry_count_now expected %0d actual %0d", $time,
                             want.entry_count_now, rsp_ch.entry_count_now);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #100_000_000;
        $display("linear_hash_table_engine regression: fail");
        $finish;
    end

    initial begin
        req_ch.valid <= 1'b0;
        req_ch.opcode <= '0;
        req_ch.key <= '0;
        req_ch.hash_value <= '0;
        req_ch.record_handle <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table(1'b0);
        test_random(1'b0);
        test_full_table(1'b1);
        test_random(1'b1);
        drain_results();
        repeat (20) @(posedge i_clk);
        if (err_count == 0 && pending_rsp.size() == 0)
            $display("linear_hash_table_engine regression: pass");
        else
            $display("linear_hash_table_engine regression: fail");
        $finish;
    end

endmodule
